>>> sv/mlw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlw_pkg
// Shared constants, sequencer states and control types for the shortest
// window search block.
// ----------------------------------------------------------------------------
package mlw_pkg;

  localparam int DEF_WINDOW_DEPTH = 1024;
  localparam int DEF_VALUE_BITS   = 16;

  localparam int TARGET_W   = 32;
  localparam int LEN_W      = 11;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(1);
  localparam logic [LEN_W-1:0]    LEN_MAX      = '1;

  // register index, taken from paddr[2]
  localparam logic REG_TARGET = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DROP_RD,
    S_DROP_SUB,
    S_WRITE,
    S_CHECK,
    S_EMIT
  } mlw_state_t;

  typedef struct packed {
    logic clear;
    logic add;
    logic sub;
  } mlw_accum_ctl_t;

endpackage

>>> sv/mlw_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlw_item_if / mlw_result_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface mlw_item_if #(
  parameter int VALUE_BITS = mlw_pkg::DEF_VALUE_BITS
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic                  last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface mlw_result_if;
  logic                        valid;
  logic                        ready;
  logic [mlw_pkg::LEN_W-1:0]   min_length;
  logic                        overflow;

  modport source (output valid, output min_length, output overflow, input ready);
  modport sink   (input valid, input min_length, input overflow, output ready);
endinterface

>>> sv/mlw_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlw_accum
// Window sum register with one shared add/subtract unit and the compare
// against the target.
// ----------------------------------------------------------------------------
module mlw_accum #(
  parameter int VALUE_BITS = mlw_pkg::DEF_VALUE_BITS,
  parameter int SUM_W      = mlw_pkg::DEF_VALUE_BITS + 11
) (
  input  logic                             clk,
  input  logic                             rst,
  input  mlw_pkg::mlw_accum_ctl_t          ctl,
  input  logic [VALUE_BITS-1:0]            operand,
  input  logic [mlw_pkg::TARGET_W-1:0]     target,
  output logic                             reach
);
  import mlw_pkg::*;

  localparam int CMP_W = (SUM_W > TARGET_W) ? SUM_W : TARGET_W;

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sum_next;
  logic [SUM_W-1:0] opx;

  // subtract as add of the inverted operand plus one
  always_comb begin
    opx      = SUM_W'(operand) ^ {SUM_W{ctl.sub}};
    sum_next = sum + opx + SUM_W'(ctl.sub);
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      sum <= '0;
    end else if (ctl.add || ctl.sub) begin
      sum <= sum_next;
    end
  end

  assign reach = CMP_W'(sum) >= CMP_W'(target);

endmodule

>>> sv/min_length_window_at_least_target.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_length_window_at_least_target
// Shortest window of a value stream whose sum reaches a target, with a
// circular window store and a sequencer around one shared adder.
// ----------------------------------------------------------------------------
// Sequence: a word is taken in S_IDLE, added and stored in S_WRITE and tested
//   in S_CHECK; a value dropped from the window front is read in S_DROP_RD and
//   subtracted in S_DROP_SUB, and a full store drops its oldest value before
//   the write; after a last word the result is registered in S_EMIT.
// Throughput: one word at a time; each value is dropped at most once.
// Reset: rst clears the window, sum, best length and flags; target returns
//   to 1. The store itself is not cleared.
// ----------------------------------------------------------------------------
module min_length_window_at_least_target #(
  parameter int WINDOW_DEPTH = mlw_pkg::DEF_WINDOW_DEPTH,
  parameter int VALUE_BITS   = mlw_pkg::DEF_VALUE_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  mlw_item_if.sink                          item,
  mlw_result_if.source                      result,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mlw_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [mlw_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [mlw_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import mlw_pkg::*;

  localparam int PTR_W  = $clog2(WINDOW_DEPTH);
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = VALUE_BITS + CNT_W;
  localparam int WIDE_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(WINDOW_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(WINDOW_DEPTH - 1);

  // config
  logic [TARGET_W-1:0] target;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TARGET) ? APB_DATA_W'(target) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= TARGET_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TARGET) begin
      target <= pwdata[TARGET_W-1:0];
    end
  end

  // state
  mlw_state_t          state, state_next;
  logic [PTR_W-1:0]    front;
  logic [PTR_W-1:0]    back;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    best;
  logic                overflow_seen;
  logic                ovf_drop;
  logic [VALUE_BITS-1:0] val;
  logic                last;
  logic [VALUE_BITS-1:0] rd_data;
  logic [VALUE_BITS-1:0] store [WINDOW_DEPTH];

  logic                out_valid;
  logic [LEN_W-1:0]    out_len;
  logic                out_ovf;

  logic                reach;
  mlw_accum_ctl_t      actl;

  logic load_item, do_read, do_drop, do_write, rec_best, emit;

  always_comb begin
    state_next = state;
    load_item  = 1'b0;
    do_read    = 1'b0;
    do_drop    = 1'b0;
    do_write   = 1'b0;
    rec_best   = 1'b0;
    emit       = 1'b0;
    item.ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        item.ready = 1'b1;
        if (item.valid) begin
          load_item  = 1'b1;
          state_next = (count == DEPTH_CNT) ? S_DROP_RD : S_WRITE;
        end
      end
      S_DROP_RD: begin
        do_read    = 1'b1;
        state_next = S_DROP_SUB;
      end
      S_DROP_SUB: begin
        do_drop    = 1'b1;
        state_next = ovf_drop ? S_WRITE : S_CHECK;
      end
      S_WRITE: begin
        do_write   = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (count != '0 && reach) begin
          rec_best   = (best == '0) || (count < best);
          state_next = S_DROP_RD;
        end else begin
          state_next = last ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (!out_valid || result.ready) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    actl.clear = emit;
    actl.add   = do_write;
    actl.sub   = do_drop;
  end

  mlw_accum #(
    .VALUE_BITS (VALUE_BITS),
    .SUM_W      (SUM_W)
  ) u_accum (
    .clk     (clk),
    .rst     (rst),
    .ctl     (actl),
    .operand (do_drop ? rd_data : val),
    .target  (target),
    .reach   (reach)
  );

  // window store
  always_ff @(posedge clk) begin
    if (do_write) begin
      store[back] <= val;
    end
    if (do_read) begin
      rd_data <= store[front];
    end
  end

  always_ff @(posedge clk) begin
    if (load_item) begin
      val  <= item.value;
      last <= item.last_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || emit) begin
      front         <= '0;
      back          <= '0;
      count         <= '0;
      best          <= '0;
      overflow_seen <= 1'b0;
      ovf_drop      <= 1'b0;
    end else begin
      if (load_item && count == DEPTH_CNT) begin
        ovf_drop      <= 1'b1;
        overflow_seen <= 1'b1;
      end
      if (do_drop) begin
        ovf_drop <= 1'b0;
        front    <= (front == LAST_PTR) ? '0 : front + PTR_W'(1);
        count    <= count - CNT_W'(1);
      end
      if (do_write) begin
        back  <= (back == LAST_PTR) ? '0 : back + PTR_W'(1);
        count <= count + CNT_W'(1);
      end
      if (rec_best) begin
        best <= count;
      end
    end
  end

  // result register, length saturates to the field width
  logic [WIDE_W-1:0] best_wide;
  logic [LEN_W-1:0]  len_sat;

  always_comb begin
    best_wide = WIDE_W'(best);
    len_sat   = (best_wide > WIDE_W'(LEN_MAX)) ? LEN_MAX : LEN_W'(best_wide);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_len <= len_sat;
      out_ovf <= overflow_seen;
    end
  end

  assign result.valid      = out_valid;
  assign result.min_length = out_len;
  assign result.overflow   = out_ovf;

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> !item.ready)
    else $error("ready high straight after an accepted word");

  a_write_fills: assert property (@(posedge clk) disable iff (rst)
    state == S_WRITE |=> count != '0)
    else $error("window empty after a write");

  a_drop_count: assert property (@(posedge clk) disable iff (rst)
    state == S_DROP_SUB |=> count == $past(count) - CNT_W'(1))
    else $error("count not decremented on drop");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK |-> count <= DEPTH_CNT && count != '0 || count == '0)
    else $error("window count beyond store depth");

  a_best_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> best <= DEPTH_CNT)
    else $error("best length beyond store depth");

endmodule

>>> tb/mlw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlw_checker
// Watches the input and result channels and the register port of the
// shortest window search block. Keeps its own window, running sum and best
// length, works out the result word owed for every last word, and compares
// each accepted result word field by field against the oldest one owed.
// ----------------------------------------------------------------------------
module mlw_checker (
  input  logic                           clk,
  input  logic                           rst,
  mlw_item_if                            item,
  mlw_result_if                          result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mlw_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mlw_pkg::APB_DATA_W-1:0] pwdata,
  input  logic                           pready,
  output int                             pending,
  output int                             errors
);
  import mlw_pkg::*;

  localparam int DEPTH = DEF_WINDOW_DEPTH;

  typedef struct packed {
    logic [LEN_W-1:0] min_length;
    logic             overflow;
  } window_result_t;

  logic [DEF_VALUE_BITS-1:0] window_q[$];
  longint unsigned           window_total;
  int unsigned               shortest;
  bit                        overflowed;
  logic [TARGET_W-1:0]       target_reg;
  window_result_t            owed_results[$];

  function automatic void clear_window();
    window_q.delete();
    window_total = 0;
    shortest     = 0;
    overflowed   = 1'b0;
  endfunction

  function automatic void absorb_value(input logic [DEF_VALUE_BITS-1:0] v, input logic last);
    window_result_t r;
    if (window_q.size() >= DEPTH) begin
      window_total -= window_q.pop_front();
      overflowed = 1'b1;
    end
    window_q.push_back(v);
    window_total += v;
    while (window_q.size() > 0 && window_total >= target_reg) begin
      if (shortest == 0 || window_q.size() < shortest)
        shortest = window_q.size();
      window_total -= window_q.pop_front();
    end
    if (last) begin
      r.min_length = (shortest > LEN_MAX) ? LEN_MAX : shortest[LEN_W-1:0];
      r.overflow   = overflowed;
      owed_results.push_back(r);
      clear_window();
    end
  endfunction

  always @(posedge clk) begin
    window_result_t want;
    if (rst) begin
      clear_window();
      target_reg = TARGET_RESET;
      owed_results.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (owed_results.size() == 0) begin
          $error("unexpected result word: min_length %0d overflow %0d",
                 result.min_length, result.overflow);
          errors++;
        end else begin
          want = owed_results.pop_front();
          if (result.min_length !== want.min_length) begin
            $error("min_length: expected %0d, got %0d", want.min_length, result.min_length);
            errors++;
          end
          if (result.overflow !== want.overflow) begin
            $error("overflow: expected %0d, got %0d", want.overflow, result.overflow);
            errors++;
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr[2] == REG_TARGET)
        target_reg = pwdata[TARGET_W-1:0];
      if (item.valid && item.ready)
        absorb_value(item.value, item.last_item);
    end
    pending <= owed_results.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the shortest window search block: a short directed run over
// the target extremes, zero values, the ignored spare register and a full
// store, then random sequences under changing targets with random idling on
// both channels, a long result stall and a quiet tail. The checker beside
// the block does all comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import mlw_pkg::*;

  localparam logic [APB_ADDR_W-1:0] ADDR_TARGET = APB_ADDR_W'(0);
  localparam logic [APB_ADDR_W-1:0] ADDR_SPARE  = APB_ADDR_W'(4);

  localparam int VM_FULL  = 0;
  localparam int VM_SMALL = 1;
  localparam int VM_EDGE  = 2;

  localparam int ITEM_GOAL = 1900;
  localparam int HOLD_LEN  = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int owed;
  int fail_count;
  int sent;
  int idle_pct;
  bit calm;
  bit hold_go;

  mlw_item_if   item_ch ();
  mlw_result_if result_ch ();

  min_length_window_at_least_target DUT (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  mlw_checker chk (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .pready  (pready),
    .pending (owed),
    .errors  (fail_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #6_000_000;
    $display("tb NOT OK");
    $finish;
  end

  task automatic pause_words(input int n);
    item_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic push_word(input logic [DEF_VALUE_BITS-1:0] v, input logic last);
    if (!calm && idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
      pause_words($urandom_range(1, 12));
    item_ch.valid     <= 1'b1;
    item_ch.value     <= v;
    item_ch.last_item <= last;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    sent++;
  endtask

  // wait for every owed result word, then let the block go quiet
  task automatic settle();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    wait (owed == 0);
    repeat (24) @(posedge clk);
  endtask

  task automatic reg_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_run(input int len, input int vmode);
    logic [DEF_VALUE_BITS-1:0] v;
    for (int k = 0; k < len; k++) begin
      case (vmode)
        VM_FULL:  v = 16'($urandom_range(1, 65535));
        VM_SMALL: v = 16'($urandom_range(1, 64));
        default:  v = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'($urandom_range(1, 3));
      endcase
      push_word(v, k == len - 1);
    end
  endtask

  function automatic logic [31:0] pick_target(input int vmode);
    case ($urandom_range(0, 9))
      0:       return 32'd1;
      1:       return 32'hFFFF_FFFF;
      default: return (vmode == VM_SMALL) ? $urandom_range(1, 800) : $urandom_range(1, 600000);
    endcase
  endfunction

  // result side: random stalls, one long hold-off on request
  initial begin
    int stall;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_go) begin
        hold_go = 1'b0;
        stall   = HOLD_LEN;
      end else if (!calm && idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        stall = $urandom_range(1, 12);
      end else begin
        stall = 0;
      end
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    int phase;
    int vmode;
    item_ch.valid     <= 1'b0;
    item_ch.value     <= '0;
    item_ch.last_item <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    idle_pct = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: target left at its reset value of one
    push_word(16'd1, 1'b1);
    settle();
    reg_write(ADDR_TARGET, 32'hFFFF_FFFF);
    push_word(16'hFFFF, 1'b0);
    push_word(16'hFFFF, 1'b1);
    settle();
    reg_write(ADDR_TARGET, 32'd0);
    push_word(16'd0, 1'b0);
    push_word(16'h8000, 1'b1);
    settle();
    reg_write(ADDR_SPARE, 32'd5);
    push_word(16'd3, 1'b1);
    settle();
    reg_write(ADDR_TARGET, 32'd100);
    push_word(16'd30, 1'b0);
    push_word(16'd0, 1'b0);
    push_word(16'd40, 1'b0);
    push_word(16'd0, 1'b0);
    push_word(16'd50, 1'b0);
    push_word(16'd1, 1'b0);
    push_word(16'd99, 1'b1);
    settle();
    reg_write(ADDR_TARGET, 32'd131070);
    push_word(16'hAAAA, 1'b0);
    push_word(16'h5555, 1'b0);
    push_word(16'hFFFF, 1'b0);
    push_word(16'hFFFF, 1'b1);

    phase = 0;
    while (sent < ITEM_GOAL - 150) begin
      vmode    = $urandom_range(VM_FULL, VM_EDGE);
      idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      settle();
      if (phase == 2) begin
        // store overruns; the last word makes a full-depth window qualify
        reg_write(ADDR_TARGET, 32'd1030);
        for (int k = 0; k < 1030; k++)
          push_word((k == 1029) ? 16'd7 : 16'd1, k == 1029);
      end else begin
        reg_write(ADDR_TARGET, pick_target(vmode));
        if (phase == 1) begin
          idle_pct = 0;
          hold_go  = 1'b1;
          repeat (12) send_run($urandom_range(1, 2), vmode);
        end else begin
          repeat ($urandom_range(3, 10))
            send_run(($urandom_range(0, 9) == 0) ? $urandom_range(40, 200)
                                                 : $urandom_range(1, 30), vmode);
        end
      end
      phase++;
    end

    calm = 1'b1;
    settle();
    reg_write(ADDR_TARGET, $urandom_range(1, 800));
    while (sent < ITEM_GOAL)
      send_run($urandom_range(1, 20), VM_SMALL);

    item_ch.valid <= 1'b0;
    @(posedge clk);
    wait (owed == 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && owed == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
